@@ hdl/rsha_pkg.sv @@
package rsha_pkg;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXISTS  = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // every record carries a four byte length word in front of its payload
    localparam logic [10:0] REC_PAD = 11'd4;

    localparam logic [2:0] ADDR_FIT_MODE = 3'd0;

    typedef enum logic [21:0] {
        S_IDLE     = 22'b0000000000000000000001,
        S_SORT_I   = 22'b0000000000000000000010,
        S_SORT_IRD = 22'b0000000000000000000100,
        S_SORT_CAP = 22'b0000000000000000001000,
        S_SORT_RD  = 22'b0000000000000000010000,
        S_SORT_CMP = 22'b0000000000000000100000,
        S_SORT_SW1 = 22'b0000000000000001000000,
        S_SORT_SW2 = 22'b0000000000000010000000,
        S_KEY_RD   = 22'b0000000000000100000000,
        S_KEY_CMP  = 22'b0000000000001000000000,
        S_DISPATCH = 22'b0000000000010000000000,
        S_FIT_RD   = 22'b0000000000100000000000,
        S_FIT_CMP  = 22'b0000000001000000000000,
        S_SHIFT_RD = 22'b0000000010000000000000,
        S_SHIFT_WR = 22'b0000000100000000000000,
        S_HFIX     = 22'b0000001000000000000000,
        S_EOD      = 22'b0000010000000000000000,
        S_ADD_WR   = 22'b0000100000000000000000,
        S_DEL_RD   = 22'b0001000000000000000000,
        S_DEL_MV   = 22'b0010000000000000000000,
        S_FIN      = 22'b0100000000000000000000,
        S_KEY_SET  = 22'b1000000000000000000000
    } state_t;

    // true when hole a goes ahead of hole b in the sorted list
    function automatic logic hole_precedes(input logic [1:0] mode,
                                           input logic [10:0] sa, input logic [31:0] oa,
                                           input logic [10:0] sb, input logic [31:0] ob);
        logic r;
        if (sa != sb) begin
            r = (mode == FIT_BEST) ? (sa < sb) : (sa > sb);
        end else begin
            r = (oa < ob);
        end
        return r;
    endfunction

endpackage

@@ hdl/record_store_hole_allocator.sv @@
// Record store with hole allocator. Keeps an index of records (key, offset,
// length) and a list of free holes (size, offset). An add reserves length+4
// bytes from a hole picked by first, best or worst fit (register fit_mode at
// byte 0), or from the end of data; a delete returns the bytes as a new hole
// at the list end; a find reports offset and length. One item is worked at a
// time through one sequencer and tables with one write and one read port
// each: the key walk reads up to every record, the fit search and list
// compaction up to every hole, and in best or worst fit mode each add with
// two or more holes first runs a selection sort over the hole list. s_ready
// is high only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken. The tables need no clearing
// pass.
module record_store_hole_allocator #(
    parameter int INDEX_DEPTH = 256,
    parameter int HOLE_DEPTH  = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [31:0] s_key,
    input  logic [9:0]         s_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_offset,
    output logic [9:0]         m_record_length,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int HW = (HOLE_DEPTH > 1) ? $clog2(HOLE_DEPTH) : 1;
    localparam logic [IW:0] RC_FULL = (IW+1)'(INDEX_DEPTH);
    localparam logic [HW:0] HC_FULL = (HW+1)'(HOLE_DEPTH);

    rsha_pkg::state_t state_reg, state_next;

    // tables
    logic [31:0] key_mem   [INDEX_DEPTH];
    logic [31:0] roff_mem  [INDEX_DEPTH];
    logic [9:0]  rlen_mem  [INDEX_DEPTH];
    logic [10:0] hsz_mem   [HOLE_DEPTH];
    logic [31:0] hoff_mem  [HOLE_DEPTH];

    logic [31:0] key_rd, roff_rd, hoff_rd;
    logic [9:0]  rlen_rd;
    logic [10:0] hsz_rd;

    logic          rec_we, hole_we;
    logic [IW-1:0] rec_waddr;
    logic [31:0]   rec_wkey, rec_woff;
    logic [9:0]    rec_wlen;
    logic [HW-1:0] hole_waddr;
    logic [10:0]   hole_wsz;
    logic [31:0]   hole_woff;

    // control and work registers
    logic [1:0]    fit_mode_reg;
    logic [IW:0]   rc_reg, rc_next;
    logic [HW:0]   hc_reg, hc_next;
    logic [31:0]   eod_reg, eod_next;
    logic [1:0]    act_reg, act_next;
    logic [31:0]   key_reg, key_next;
    logic [9:0]    len_reg, len_next;
    logic [IW-1:0] kidx_reg, kidx_next;
    logic [IW-1:0] ridx_reg, ridx_next;
    logic          found_reg, found_next;
    logic [HW-1:0] hidx_reg, hidx_next;
    logic [HW-1:0] si_reg, si_next;
    logic [HW-1:0] bi_reg, bi_next;
    logic [10:0]   best_sz_reg, best_sz_next, cur_sz_reg, cur_sz_next;
    logic [31:0]   best_off_reg, best_off_next, cur_off_reg, cur_off_next;
    logic [10:0]   ns_reg, ns_next;
    logic [31:0]   no_reg, no_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic [31:0]   res_off_reg, res_off_next;
    logic [9:0]    res_len_reg, res_len_next;
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_st_reg, m_st_next;
    logic [31:0]   m_off_reg, m_off_next;
    logic [9:0]    m_len_reg, m_len_next;

    logic [10:0] need;
    logic [HW:0] hidx_inc, si_inc2;
    logic [IW:0] kidx_inc;
    logic [32:0] eod_sum;
    logic        sorting_mode;

    assign need         = {1'b0, len_reg} + rsha_pkg::REC_PAD;
    assign hidx_inc     = {1'b0, hidx_reg} + (HW+1)'(1);
    assign si_inc2      = {1'b0, si_reg} + (HW+1)'(2);
    assign kidx_inc     = {1'b0, kidx_reg} + (IW+1)'(1);
    assign eod_sum      = {1'b0, eod_reg} + {22'd0, need};
    assign sorting_mode = (fit_mode_reg == rsha_pkg::FIT_BEST) ||
                          (fit_mode_reg == rsha_pkg::FIT_WORST);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == rsha_pkg::ADDR_FIT_MODE) ? {30'd0, fit_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= rsha_pkg::FIT_FIRST;
        end else if (psel && penable && pwrite && pready &&
                     paddr == rsha_pkg::ADDR_FIT_MODE) begin
            fit_mode_reg <= pwdata[1:0];
        end
    end

    // table ports: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (rec_we) begin
            key_mem[rec_waddr]  <= rec_wkey;
            roff_mem[rec_waddr] <= rec_woff;
            rlen_mem[rec_waddr] <= rec_wlen;
        end
        key_rd  <= key_mem[kidx_reg];
        roff_rd <= roff_mem[kidx_reg];
        rlen_rd <= rlen_mem[kidx_reg];
    end

    always_ff @(posedge aclk) begin
        if (hole_we) begin
            hsz_mem[hole_waddr]  <= hole_wsz;
            hoff_mem[hole_waddr] <= hole_woff;
        end
        hsz_rd  <= hsz_mem[hidx_reg];
        hoff_rd <= hoff_mem[hidx_reg];
    end

    assign s_ready         = (state_reg == rsha_pkg::S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_st_reg;
    assign m_offset        = m_off_reg;
    assign m_record_length = m_len_reg;

    always_comb begin
        state_next    = state_reg;
        rc_next       = rc_reg;
        hc_next       = hc_reg;
        eod_next      = eod_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        len_next      = len_reg;
        kidx_next     = kidx_reg;
        ridx_next     = ridx_reg;
        found_next    = found_reg;
        hidx_next     = hidx_reg;
        si_next       = si_reg;
        bi_next       = bi_reg;
        best_sz_next  = best_sz_reg;
        best_off_next = best_off_reg;
        cur_sz_next   = cur_sz_reg;
        cur_off_next  = cur_off_reg;
        ns_next       = ns_reg;
        no_next       = no_reg;
        res_st_next   = res_st_reg;
        res_off_next  = res_off_reg;
        res_len_next  = res_len_reg;
        m_valid_next  = m_valid_reg;
        m_st_next     = m_st_reg;
        m_off_next    = m_off_reg;
        m_len_next    = m_len_reg;
        rec_we        = 1'b0;
        rec_waddr     = kidx_reg;
        rec_wkey      = key_reg;
        rec_woff      = res_off_reg;
        rec_wlen      = len_reg;
        hole_we       = 1'b0;
        hole_waddr    = hidx_reg;
        hole_wsz      = best_sz_reg;
        hole_woff     = best_off_reg;

        // drop the result once the beat is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            rsha_pkg::S_IDLE: begin
                if (s_valid) begin
                    act_next     = s_action;
                    key_next     = s_key;
                    len_next     = s_length;
                    res_st_next  = rsha_pkg::ST_OK;
                    res_off_next = 32'd0;
                    res_len_next = 10'd0;
                    found_next   = 1'b0;
                    kidx_next    = '0;
                    hidx_next    = '0;
                    si_next      = '0;
                    if (s_action == rsha_pkg::ACT_NOP) begin
                        state_next = rsha_pkg::S_FIN;
                    end else if (s_action == rsha_pkg::ACT_ADD && sorting_mode &&
                                 hc_reg >= (HW+1)'(2)) begin
                        state_next = rsha_pkg::S_SORT_IRD;
                    end else begin
                        state_next = rsha_pkg::S_KEY_SET;
                    end
                end
            end
            // selection sort: one pass per position, swap at its end
            rsha_pkg::S_SORT_I: begin
                hidx_next  = si_reg;
                state_next = rsha_pkg::S_SORT_IRD;
            end
            rsha_pkg::S_SORT_IRD: begin
                state_next = rsha_pkg::S_SORT_CAP;
            end
            rsha_pkg::S_SORT_CAP: begin
                cur_sz_next   = hsz_rd;
                cur_off_next  = hoff_rd;
                best_sz_next  = hsz_rd;
                best_off_next = hoff_rd;
                bi_next       = si_reg;
                hidx_next     = hidx_inc[HW-1:0];
                state_next    = rsha_pkg::S_SORT_RD;
            end
            rsha_pkg::S_SORT_RD: begin
                state_next = rsha_pkg::S_SORT_CMP;
            end
            rsha_pkg::S_SORT_CMP: begin
                if (rsha_pkg::hole_precedes(fit_mode_reg, hsz_rd, hoff_rd,
                                            best_sz_reg, best_off_reg)) begin
                    best_sz_next  = hsz_rd;
                    best_off_next = hoff_rd;
                    bi_next       = hidx_reg;
                end
                if (hidx_inc < hc_reg) begin
                    hidx_next  = hidx_inc[HW-1:0];
                    state_next = rsha_pkg::S_SORT_RD;
                end else begin
                    state_next = rsha_pkg::S_SORT_SW1;
                end
            end
            rsha_pkg::S_SORT_SW1: begin
                hole_we    = 1'b1;
                hole_waddr = si_reg;
                state_next = rsha_pkg::S_SORT_SW2;
            end
            rsha_pkg::S_SORT_SW2: begin
                hole_we    = 1'b1;
                hole_waddr = bi_reg;
                hole_wsz   = cur_sz_reg;
                hole_woff  = cur_off_reg;
                si_next    = si_reg + HW'(1);
                if (si_inc2 < hc_reg) begin
                    state_next = rsha_pkg::S_SORT_I;
                end else begin
                    state_next = rsha_pkg::S_KEY_SET;
                end
            end
            rsha_pkg::S_KEY_SET: begin
                kidx_next = '0;
                if (rc_reg == '0) begin
                    state_next = rsha_pkg::S_DISPATCH;
                end else begin
                    state_next = rsha_pkg::S_KEY_RD;
                end
            end
            rsha_pkg::S_KEY_RD: begin
                state_next = rsha_pkg::S_KEY_CMP;
            end
            rsha_pkg::S_KEY_CMP: begin
                if (key_rd == key_reg) begin
                    found_next   = 1'b1;
                    ridx_next    = kidx_reg;
                    res_off_next = roff_rd;
                    res_len_next = rlen_rd;
                    state_next   = rsha_pkg::S_DISPATCH;
                end else if (kidx_inc < rc_reg) begin
                    kidx_next  = kidx_inc[IW-1:0];
                    state_next = rsha_pkg::S_KEY_RD;
                end else begin
                    state_next = rsha_pkg::S_DISPATCH;
                end
            end
            rsha_pkg::S_DISPATCH: begin
                state_next = rsha_pkg::S_FIN;
                case (act_reg)
                    rsha_pkg::ACT_ADD: begin
                        if (found_reg) begin
                            res_st_next = rsha_pkg::ST_EXISTS;
                        end else if (rc_reg >= RC_FULL) begin
                            res_st_next = rsha_pkg::ST_FULL;
                        end else if (hc_reg == '0) begin
                            state_next = rsha_pkg::S_EOD;
                        end else begin
                            hidx_next  = '0;
                            state_next = rsha_pkg::S_FIT_RD;
                        end
                    end
                    rsha_pkg::ACT_FIND: begin
                        if (!found_reg) begin
                            res_st_next = rsha_pkg::ST_MISSING;
                        end
                    end
                    rsha_pkg::ACT_DELETE: begin
                        if (!found_reg) begin
                            res_st_next = rsha_pkg::ST_MISSING;
                        end else if (hc_reg >= HC_FULL) begin
                            res_st_next = rsha_pkg::ST_FULL;
                        end else begin
                            // free the bytes, then pull the last record into the gap
                            hole_we    = 1'b1;
                            hole_waddr = hc_reg[HW-1:0];
                            hole_wsz   = {1'b0, res_len_reg} + rsha_pkg::REC_PAD;
                            hole_woff  = res_off_reg;
                            hc_next    = hc_reg + (HW+1)'(1);
                            kidx_next  = IW'(rc_reg - (IW+1)'(1));
                            state_next = rsha_pkg::S_DEL_RD;
                        end
                    end
                    default: begin
                        res_st_next = rsha_pkg::ST_OK;
                    end
                endcase
            end
            rsha_pkg::S_FIT_RD: begin
                state_next = rsha_pkg::S_FIT_CMP;
            end
            rsha_pkg::S_FIT_CMP: begin
                if (hsz_rd >= need) begin
                    res_off_next = hoff_rd;
                    ns_next      = hsz_rd - need;
                    no_next      = hoff_rd + {21'd0, need};
                    if (hidx_inc < hc_reg) begin
                        hidx_next  = hidx_inc[HW-1:0];
                        state_next = rsha_pkg::S_SHIFT_RD;
                    end else begin
                        state_next = rsha_pkg::S_HFIX;
                    end
                end else if (hidx_inc < hc_reg) begin
                    hidx_next  = hidx_inc[HW-1:0];
                    state_next = rsha_pkg::S_FIT_RD;
                end else begin
                    state_next = rsha_pkg::S_EOD;
                end
            end
            rsha_pkg::S_SHIFT_RD: begin
                state_next = rsha_pkg::S_SHIFT_WR;
            end
            rsha_pkg::S_SHIFT_WR: begin
                hole_we    = 1'b1;
                hole_waddr = hidx_reg - HW'(1);
                hole_wsz   = hsz_rd;
                hole_woff  = hoff_rd;
                if (hidx_inc < hc_reg) begin
                    hidx_next  = hidx_inc[HW-1:0];
                    state_next = rsha_pkg::S_SHIFT_RD;
                end else begin
                    state_next = rsha_pkg::S_HFIX;
                end
            end
            rsha_pkg::S_HFIX: begin
                // remainder goes to the list end, or leaves when empty
                if (ns_reg == 11'd0) begin
                    hc_next = hc_reg - (HW+1)'(1);
                end else begin
                    hole_we    = 1'b1;
                    hole_waddr = HW'(hc_reg - (HW+1)'(1));
                    hole_wsz   = ns_reg;
                    hole_woff  = no_reg;
                end
                state_next = rsha_pkg::S_ADD_WR;
            end
            rsha_pkg::S_EOD: begin
                if (eod_sum[32]) begin
                    res_st_next = rsha_pkg::ST_FULL;
                    state_next  = rsha_pkg::S_FIN;
                end else begin
                    res_off_next = eod_reg;
                    eod_next     = eod_sum[31:0];
                    state_next   = rsha_pkg::S_ADD_WR;
                end
            end
            rsha_pkg::S_ADD_WR: begin
                rec_we       = 1'b1;
                rec_waddr    = rc_reg[IW-1:0];
                rc_next      = rc_reg + (IW+1)'(1);
                res_len_next = len_reg;
                res_st_next  = rsha_pkg::ST_OK;
                state_next   = rsha_pkg::S_FIN;
            end
            rsha_pkg::S_DEL_RD: begin
                state_next = rsha_pkg::S_DEL_MV;
            end
            rsha_pkg::S_DEL_MV: begin
                rec_we     = 1'b1;
                rec_waddr  = ridx_reg;
                rec_wkey   = key_rd;
                rec_woff   = roff_rd;
                rec_wlen   = rlen_rd;
                rc_next    = rc_reg - (IW+1)'(1);
                state_next = rsha_pkg::S_FIN;
            end
            rsha_pkg::S_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_st_next    = res_st_reg;
                    m_off_next   = res_off_reg;
                    m_len_next   = res_len_reg;
                    state_next   = rsha_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rsha_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsha_pkg::S_IDLE;
            rc_reg      <= '0;
            hc_reg      <= '0;
            eod_reg     <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rc_reg      <= rc_next;
            hc_reg      <= hc_next;
            eod_reg     <= eod_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        len_reg      <= len_next;
        kidx_reg     <= kidx_next;
        ridx_reg     <= ridx_next;
        found_reg    <= found_next;
        hidx_reg     <= hidx_next;
        si_reg       <= si_next;
        bi_reg       <= bi_next;
        best_sz_reg  <= best_sz_next;
        best_off_reg <= best_off_next;
        cur_sz_reg   <= cur_sz_next;
        cur_off_reg  <= cur_off_next;
        ns_reg       <= ns_next;
        no_reg       <= no_next;
        res_st_reg   <= res_st_next;
        res_off_reg  <= res_off_next;
        res_len_reg  <= res_len_next;
        m_st_reg     <= m_st_next;
        m_off_reg    <= m_off_next;
        m_len_reg    <= m_len_next;
    end

    a_rc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_reg <= RC_FULL) else $error("record count beyond index depth");

    a_hc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hc_reg <= HC_FULL) else $error("hole count beyond list depth");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready held after input beat");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == rsha_pkg::S_FIN))
        else $error("result raised outside finish state");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;

    // ---------------------------------------------------------------
    // Clock, reset and wiring
    // ---------------------------------------------------------------
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = rsha_pkg::ACT_NOP;
    logic signed [31:0] s_key = '0;
    logic [9:0]         s_length = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [31:0]        m_offset;
    logic [9:0]         m_record_length;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    always #5 aclk = ~aclk;

    record_store_hole_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_key(s_key), .s_length(s_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_offset(m_offset), .m_record_length(m_record_length),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int INDEX_DEPTH = 256;
    localparam int HOLE_DEPTH  = 256;
    localparam int CYCLE_LIMIT = 300_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] offset;
        logic [9:0]  rec_len;
    } outcome_t;

    // ---------------------------------------------------------------
    // Shadow copy of the store: index, hole list, fill mark, fit mode
    // ---------------------------------------------------------------
    logic [31:0] sh_key   [INDEX_DEPTH];
    logic [31:0] sh_off   [INDEX_DEPTH];
    logic [9:0]  sh_len   [INDEX_DEPTH];
    logic [10:0] sh_hsize [HOLE_DEPTH];
    logic [31:0] sh_hoff  [HOLE_DEPTH];
    int          sh_nrec;
    int          sh_nhole;
    logic [31:0] sh_eod;
    logic [1:0]  sh_mode;

    outcome_t    pending_q[$];
    int          mismatches;
    int          results_seen;
    int          cycles;
    int          n_ok, n_exists, n_missing, n_full;

    // true when hole a must sit ahead of hole b after the sort
    function automatic bit goes_first(logic [1:0] md, logic [10:0] sa, logic [31:0] oa,
                                      logic [10:0] sb, logic [31:0] ob);
        if (sa != sb) return (md == rsha_pkg::FIT_BEST) ? (sa < sb) : (sa > sb);
        return oa < ob;
    endfunction

    function automatic int find_record(logic [31:0] k);
        for (int i = 0; i < sh_nrec; i++)
            if (sh_key[i] == k) return i;
        return -1;
    endfunction

    // work out the result of one beat and advance the shadow store
    function automatic outcome_t store_outcome(logic [1:0] act, logic [31:0] k,
                                               logic [9:0] ln);
        outcome_t    o;
        int          r, h, j;
        logic [10:0] need, ts;
        logic [31:0] to, place;
        o = '0;
        if (act == rsha_pkg::ACT_ADD) begin
            need = {1'b0, ln} + rsha_pkg::REC_PAD;
            // sort the holes even when the add ends up rejected
            if (sh_mode == rsha_pkg::FIT_BEST || sh_mode == rsha_pkg::FIT_WORST) begin
                for (int i = 1; i < sh_nhole; i++) begin
                    ts = sh_hsize[i];
                    to = sh_hoff[i];
                    j = i;
                    while (j > 0 &&
                           goes_first(sh_mode, ts, to, sh_hsize[j-1], sh_hoff[j-1])) begin
                        sh_hsize[j] = sh_hsize[j-1];
                        sh_hoff[j]  = sh_hoff[j-1];
                        j--;
                    end
                    sh_hsize[j] = ts;
                    sh_hoff[j]  = to;
                end
            end
            r = find_record(k);
            if (r >= 0) begin
                o.status  = rsha_pkg::ST_EXISTS;
                o.offset  = sh_off[r];
                o.rec_len = sh_len[r];
            end else if (sh_nrec >= INDEX_DEPTH) begin
                o.status = rsha_pkg::ST_FULL;
            end else begin
                h = -1;
                for (int i = 0; i < sh_nhole; i++)
                    if (h < 0 && sh_hsize[i] >= need) h = i;
                if (h >= 0) begin
                    place = sh_hoff[h];
                    ts = sh_hsize[h] - need;
                    to = sh_hoff[h] + need;
                    for (int i = h + 1; i < sh_nhole; i++) begin
                        sh_hsize[i-1] = sh_hsize[i];
                        sh_hoff[i-1]  = sh_hoff[i];
                    end
                    // the remainder goes to the list end, or drops out when empty
                    if (ts == 0) sh_nhole--;
                    else begin
                        sh_hsize[sh_nhole-1] = ts;
                        sh_hoff[sh_nhole-1]  = to;
                    end
                end else if ({1'b0, sh_eod} + need > 33'hFFFF_FFFF) begin
                    o.status = rsha_pkg::ST_FULL;
                end else begin
                    place  = sh_eod;
                    sh_eod = sh_eod + need;
                end
                if (o.status == rsha_pkg::ST_OK) begin
                    sh_key[sh_nrec] = k;
                    sh_off[sh_nrec] = place;
                    sh_len[sh_nrec] = ln;
                    sh_nrec++;
                    o.offset  = place;
                    o.rec_len = ln;
                end
            end
        end else if (act == rsha_pkg::ACT_FIND || act == rsha_pkg::ACT_DELETE) begin
            r = find_record(k);
            if (r < 0) o.status = rsha_pkg::ST_MISSING;
            else begin
                o.offset  = sh_off[r];
                o.rec_len = sh_len[r];
                if (act == rsha_pkg::ACT_DELETE) begin
                    if (sh_nhole >= HOLE_DEPTH) o.status = rsha_pkg::ST_FULL;
                    else begin
                        sh_hsize[sh_nhole] = {1'b0, sh_len[r]} + rsha_pkg::REC_PAD;
                        sh_hoff[sh_nhole]  = sh_off[r];
                        sh_nhole++;
                        sh_key[r] = sh_key[sh_nrec-1];
                        sh_off[r] = sh_off[sh_nrec-1];
                        sh_len[r] = sh_len[sh_nrec-1];
                        sh_nrec--;
                    end
                end
            end
        end
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Cycle counter and timeout
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, compare each beat with the oldest entry
    // ---------------------------------------------------------------
    bit calm;       // no more stalls in the closing stretch
    int stall_left;
    int run_left;

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("Unexpected result beat: status %0d offset %0d len %0d",
                             m_status, m_offset, m_record_length);
            end else begin
                want = pending_q.pop_front();
                case (want.status)
                    rsha_pkg::ST_OK:      n_ok      <= n_ok + 1;
                    rsha_pkg::ST_EXISTS:  n_exists  <= n_exists + 1;
                    rsha_pkg::ST_MISSING: n_missing <= n_missing + 1;
                    default:              n_full    <= n_full + 1;
                endcase
                if (m_status !== want.status || m_offset !== want.offset ||
                    m_record_length !== want.rec_len) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: status %0d/%0d offset %0d/%0d len %0d/%0d (exp/got)",
                                 want.status, m_status, want.offset, m_offset,
                                 want.rec_len, m_record_length);
                end
            end
        end
        // hold off in bursts, with runs of full throughput between them
        if (calm) m_ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
            m_ready <= 1'b1;
        end else if ($urandom_range(3) == 0) begin
            stall_left <= $urandom_range(17, 1) - 1;
            m_ready <= 1'b0;
        end else begin
            run_left <= $urandom_range(40);
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic write_fit_mode(logic [1:0] md);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= rsha_pkg::ADDR_FIT_MODE; pwdata <= {30'd0, md};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sh_mode = md;
    endtask

    // present one beat, hold it until taken, then queue its expectation;
    // valid stays up after the beat until the next item or an idle gap
    task automatic send_item(logic [1:0] act, logic [31:0] k, logic [9:0] ln,
                             bit gaps, bit typed, outcome_t typed_out);
        outcome_t got;
        if (gaps && $urandom_range(4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1; s_action <= act; s_key <= k; s_length <= ln;
        do @(posedge aclk); while (!s_ready);
        got = store_outcome(act, k, ln);
        // a typed-in row must agree with the shadow store as well
        if (typed && got !== typed_out) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("Directed row act %0d key %0h: typed %0d/%0d/%0d predicted %0d/%0d/%0d",
                         act, k, typed_out.status, typed_out.offset, typed_out.rec_len,
                         got.status, got.offset, got.rec_len);
        end
        pending_q.push_back(got);
    endtask

    // wait until every expected beat is back, then let the sequencer settle
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    typedef struct {
        logic [1:0]  act;
        logic [31:0] key;
        logic [9:0]  len;
        bit          typed;
        outcome_t    res;
    } row_t;

    row_t dir_rows[$];

    function automatic row_t mk(logic [1:0] a, logic [31:0] k, logic [9:0] l,
                                bit t, logic [1:0] st, logic [31:0] o, logic [9:0] rl);
        row_t r;
        r.act = a; r.key = k; r.len = l; r.typed = t;
        r.res.status = st; r.res.offset = o; r.res.rec_len = rl;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    logic [31:0] live_keys[$];
    logic [31:0] kk;
    logic [1:0]  aa;
    int          pick, r;

    initial begin
        sh_nrec = 0; sh_nhole = 0; sh_eod = '0; sh_mode = rsha_pkg::FIT_FIRST;
        mismatches = 0; results_seen = 0; cycles = 0;
        n_ok = 0; n_exists = 0; n_missing = 0; n_full = 0;
        calm = 1'b0; stall_left = 0; run_left = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // fresh store: misses, an empty nop, appends at the end of data
        dir_rows.push_back(mk(rsha_pkg::ACT_FIND,   32'h0000_0000, 10'd0,   1,
                              rsha_pkg::ST_MISSING, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_DELETE, 32'h8000_0000, 10'd0,   1,
                              rsha_pkg::ST_MISSING, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_NOP,    32'hFFFF_FFFF, 10'h3FF, 1,
                              rsha_pkg::ST_OK,      0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h8000_0000, 10'd0,   1,
                              rsha_pkg::ST_OK,      0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h7FFF_FFFF, 10'h3FF, 1,
                              rsha_pkg::ST_OK,      4, 10'h3FF));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h7FFF_FFFF, 10'd5,   1,
                              rsha_pkg::ST_EXISTS,  4, 10'h3FF));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'hFFFF_FFFF, 10'd12,  0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h0000_0000, 10'd100, 0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h5555_5555, 10'h2AA, 0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_FIND,   32'h8000_0000, 10'd0,   1,
                              rsha_pkg::ST_OK,      0, 0));
        // free holes, then refill them partly and append at the end of data
        dir_rows.push_back(mk(rsha_pkg::ACT_DELETE, 32'h7FFF_FFFF, 10'd0,   1,
                              rsha_pkg::ST_OK,      4, 10'h3FF));
        dir_rows.push_back(mk(rsha_pkg::ACT_DELETE, 32'h0000_0000, 10'd0,   0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_FIND,   32'h7FFF_FFFF, 10'd0,   1,
                              rsha_pkg::ST_MISSING, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h0000_0001, 10'd100, 0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h0000_0002, 10'd20,  0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_ADD,    32'h0000_0003, 10'h3FF, 0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_DELETE, 32'hFFFF_FFFF, 10'd0,   0, 0, 0, 0));
        dir_rows.push_back(mk(rsha_pkg::ACT_FIND,   32'h5555_5555, 10'd0,   0, 0, 0, 0));

        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].len, 0,
                      dir_rows[i].typed, dir_rows[i].res);
        drain();

        // random phases through every fit mode, the unused code among them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_fit_mode(rsha_pkg::FIT_BEST);
                1: write_fit_mode(rsha_pkg::FIT_WORST);
                2: write_fit_mode(2'd3);
                3: write_fit_mode(rsha_pkg::FIT_FIRST);
                default: write_fit_mode(rsha_pkg::FIT_WORST);
            endcase
            live_keys.delete();
            for (int i = 0; i < sh_nrec; i++) live_keys.push_back(sh_key[i]);
            if (ph == 4) calm = 1'b1;
            for (int n = 0; n < 200; n++) begin
                pick = $urandom_range(99);
                // mostly adds and deletes of known keys, to churn the hole list
                if (pick < 40) aa = rsha_pkg::ACT_ADD;
                else if (pick < 70) aa = rsha_pkg::ACT_DELETE;
                else if (pick < 92) aa = rsha_pkg::ACT_FIND;
                else aa = rsha_pkg::ACT_NOP;
                if (live_keys.size() != 0 && $urandom_range(9) < 7 &&
                    aa != rsha_pkg::ACT_ADD) begin
                    r = $urandom_range(live_keys.size() - 1);
                    kk = live_keys[r];
                end else if (live_keys.size() != 0 && $urandom_range(9) == 0) begin
                    kk = live_keys[$urandom_range(live_keys.size() - 1)];
                end else if ($urandom_range(3) == 0) begin
                    kk = $urandom_range(15);
                end else kk = $urandom;
                send_item(aa, kk, ($urandom_range(7) == 0) ? 10'($urandom) :
                          10'($urandom_range(63)), !calm, 0, '0);
                if (aa == rsha_pkg::ACT_ADD && find_record(kk) >= 0) begin
                    if (!(kk inside {live_keys})) live_keys.push_back(kk);
                end
                if (aa == rsha_pkg::ACT_DELETE && find_record(kk) < 0) begin
                    foreach (live_keys[i])
                        if (live_keys[i] == kk) begin
                            live_keys.delete(i);
                            break;
                        end
                end
            end
            drain();
        end

        $display("Checked %0d result beats: %0d ok, %0d duplicate, %0d missing, %0d full",
                 results_seen, n_ok, n_exists, n_missing, n_full);
        $display("All fit modes exercised; %0d records and %0d holes left at the end",
                 sh_nrec, sh_nhole);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ record_store_hole_allocator.f @@
hdl/rsha_pkg.sv
hdl/record_store_hole_allocator.sv
bench/tb.sv
